// ----- rtl/skt_pkg.sv -----
// Package: shared constants, command and status codes, and the record type for sorted_key_table.
`default_nettype none
package skt_pkg;
   localparam int CAPACITY_DEF = 32;
   localparam int KEY_W = 16;
   localparam int CNT_W = 16;
   localparam int CMD_W = 3;
   localparam int ST_W = 3;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIST = 3'd4;

   localparam logic [ST_W-1:0] ST_OK = 3'd0;
   localparam logic [ST_W-1:0] ST_DUP = 3'd1;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL = 3'd3;
   localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] borrowed;
   } rec_type;
endpackage
`default_nettype wire

// ----- rtl/skt_mem.sv -----
// Record memory: one write port, one registered read port.
`default_nettype none
module skt_mem #(
   parameter int DEPTH = skt_pkg::CAPACITY_DEF,
   parameter int AW = $clog2(DEPTH)
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire skt_pkg::rec_type wr_data,
   input wire logic [AW-1:0] rd_addr,
   output skt_pkg::rec_type rd_data
);
   skt_pkg::rec_type mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/sorted_key_table.sv -----
// Top level: sorted record table sequencer over one record memory.
// Commands scan from entry 0, one entry per cycle, to the key or the first larger key;
// update then writes the record, insert shifts the tail up and then writes (or only
// writes when appending), and delete shifts the tail down.
// List first reads entry 0, then sends one record per cycle; the receiver never stalls.
// Empty list/delete and undefined commands end at acceptance; reset empties the table.
`default_nettype none
module sorted_key_table #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [skt_pkg::CMD_W-1:0] req_cmd,
   input wire logic [skt_pkg::KEY_W-1:0] req_key,
   input wire logic [skt_pkg::CNT_W-1:0] req_total_count,
   input wire logic [skt_pkg::CNT_W-1:0] req_borrowed_count,
   output logic rsp_valid,
   output logic [skt_pkg::ST_W-1:0] rsp_status,
   output logic [skt_pkg::KEY_W-1:0] rsp_out_key,
   output logic [skt_pkg::CNT_W-1:0] rsp_out_total,
   output logic [skt_pkg::CNT_W-1:0] rsp_out_borrowed,
   output logic signed [skt_pkg::CNT_W:0] rsp_out_remaining,
   output logic rsp_last
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_LIST, S_WRITE
   } state_type;

   state_type state_ff;
   logic [skt_pkg::CMD_W-1:0] cmd_ff;
   skt_pkg::rec_type req_ff, hit_ff;
   logic [CW-1:0] count_ff, idx_ff, pos_ff;
   logic pend_ff;  // read data valid for entry idx_ff-1

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   skt_pkg::rec_type wr_data, rd_data;

   skt_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [CW-1:0] prev_idx;
   assign prev_idx = idx_ff - CW'(1);

   always_comb begin
      wr_en = 1'b0;
      wr_addr = AW'(idx_ff);
      wr_data = rd_data;
      rd_addr = AW'(idx_ff);
      unique case (state_ff)
         S_SHUP: begin
            // read idx-1 first; then write it to idx while reading idx-2
            rd_addr = pend_ff ? AW'(idx_ff - CW'(2)) : AW'(prev_idx);
            if (pend_ff) begin
               wr_en = 1'b1;
            end
         end
         S_SHDN: begin
            rd_addr = AW'(idx_ff + CW'(1));
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(prev_idx);
            end
         end
         S_WRITE: begin
            wr_en = 1'b1;
            wr_addr = AW'(pos_ff);
            wr_data = (cmd_ff == skt_pkg::CMD_INSERT) ? req_ff
               : skt_pkg::rec_type'{key: hit_ff.key, total: req_ff.total,
                                    borrowed: req_ff.borrowed};
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   task automatic send(output logic fire, input logic [skt_pkg::ST_W-1:0] st,
                       input skt_pkg::rec_type r, input logic fin);
      fire = 1'b1;
      rsp_status <= st;
      rsp_out_key <= r.key;
      rsp_out_total <= r.total;
      rsp_out_borrowed <= r.borrowed;
      rsp_out_remaining <= $signed({1'b0, r.total}) - $signed({1'b0, r.borrowed});
      rsp_last <= fin;
   endtask

   always_ff @(posedge clock) begin
      logic fire;
      fire = 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid <= 1'b0;
         rsp_last <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff <= req_cmd;
                  req_ff <= '{key: req_key, total: req_total_count,
                              borrowed: req_borrowed_count};
                  idx_ff <= '0;
                  pend_ff <= 1'b0;
                  priority if (req_cmd == skt_pkg::CMD_LIST) begin
                     if (count_ff == '0) send(fire, skt_pkg::ST_EMPTY, '0, 1'b1);
                     else state_ff <= S_LIST;
                  end else if (req_cmd == skt_pkg::CMD_DELETE && count_ff == '0) begin
                     send(fire, skt_pkg::ST_EMPTY, '0, 1'b1);
                  end else if (req_cmd <= skt_pkg::CMD_DELETE) begin
                     state_ff <= S_SCAN;
                  end else begin
                     // drop undefined commands
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_SCAN: begin
               // read entry idx, compare entry idx-1
               if (pend_ff && rd_data.key >= req_ff.key) begin
                  pos_ff <= prev_idx;
                  hit_ff <= rd_data;
                  if (rd_data.key == req_ff.key) begin
                     unique case (cmd_ff)
                        skt_pkg::CMD_INSERT: begin
                           send(fire, skt_pkg::ST_DUP, '0, 1'b1);
                           state_ff <= S_IDLE;
                        end
                        skt_pkg::CMD_LOOKUP: begin
                           send(fire, skt_pkg::ST_OK, rd_data, 1'b1);
                           state_ff <= S_IDLE;
                        end
                        skt_pkg::CMD_UPDATE: begin
                           send(fire, skt_pkg::ST_OK, '{key: rd_data.key,
                              total: req_ff.total, borrowed: req_ff.borrowed}, 1'b1);
                           state_ff <= S_WRITE;
                        end
                        default: begin
                           send(fire, skt_pkg::ST_OK, rd_data, 1'b1);
                           idx_ff <= prev_idx;
                           pend_ff <= 1'b0;
                           state_ff <= S_SHDN;
                        end
                     endcase
                  end else if (cmd_ff == skt_pkg::CMD_INSERT) begin
                     if (count_ff == CAP_C) begin
                        send(fire, skt_pkg::ST_FULL, '0, 1'b1);
                        state_ff <= S_IDLE;
                     end else begin
                        idx_ff <= count_ff;
                        pend_ff <= 1'b0;
                        state_ff <= S_SHUP;
                     end
                  end else begin
                     send(fire, skt_pkg::ST_NOTFOUND, '0, 1'b1);
                     state_ff <= S_IDLE;
                  end
               end else if (idx_ff == count_ff) begin
                  // key beyond every record
                  pos_ff <= count_ff;
                  if (cmd_ff != skt_pkg::CMD_INSERT) begin
                     send(fire, skt_pkg::ST_NOTFOUND, '0, 1'b1);
                     state_ff <= S_IDLE;
                  end else if (count_ff == CAP_C) begin
                     send(fire, skt_pkg::ST_FULL, '0, 1'b1);
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_WRITE;
                  end
               end else begin
                  idx_ff <= idx_ff + CW'(1);
                  pend_ff <= 1'b1;
               end
            end
            S_SHUP: begin
               // move entry idx-1 to idx, walking down to pos
               if (idx_ff == pos_ff) begin
                  state_ff <= S_WRITE;
               end else if (pend_ff) begin
                  idx_ff <= prev_idx;
               end else begin
                  pend_ff <= 1'b1;
               end
            end
            S_SHDN: begin
               // move entry idx+1 to idx, walking up to count-1
               if (idx_ff + CW'(1) >= count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
                  pend_ff <= 1'b1;
               end
            end
            S_LIST: begin
               if (pend_ff) begin
                  send(fire, skt_pkg::ST_OK, rd_data, idx_ff == count_ff);
               end
               if (idx_ff == count_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
                  pend_ff <= 1'b1;
               end
            end
            S_WRITE: begin
               if (cmd_ff == skt_pkg::CMD_INSERT) begin
                  send(fire, skt_pkg::ST_OK, req_ff, 1'b1);
                  count_ff <= count_ff + CW'(1);
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         rsp_valid <= fire;
      end
   end
endmodule
`default_nettype wire

// ----- tb/skt_checker.sv -----
// Checker: watches the command and response channels, predicts table results and compares.
`timescale 1ns / 100ps
`default_nettype none
module skt_checker #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic [skt_pkg::CMD_W-1:0] req_cmd,
   input wire logic [skt_pkg::KEY_W-1:0] req_key,
   input wire logic [skt_pkg::CNT_W-1:0] req_total_count,
   input wire logic [skt_pkg::CNT_W-1:0] req_borrowed_count,
   input wire logic rsp_valid,
   input wire logic [skt_pkg::ST_W-1:0] rsp_status,
   input wire logic [skt_pkg::KEY_W-1:0] rsp_out_key,
   input wire logic [skt_pkg::CNT_W-1:0] rsp_out_total,
   input wire logic [skt_pkg::CNT_W-1:0] rsp_out_borrowed,
   input wire logic signed [skt_pkg::CNT_W:0] rsp_out_remaining,
   input wire logic rsp_last,
   output int fail_count,
   output int pending_count,
   output int table_count
);
   typedef struct {
      logic [skt_pkg::ST_W-1:0] status;
      logic [skt_pkg::KEY_W-1:0] key;
      logic [skt_pkg::CNT_W-1:0] total;
      logic [skt_pkg::CNT_W-1:0] borrowed;
      logic [skt_pkg::CNT_W:0] remaining;
      logic last;
   } rsp_rec_type;

   skt_pkg::rec_type shadow_table[$];
   rsp_rec_type expected_rsp[$];

   function automatic rsp_rec_type make_rsp(logic [skt_pkg::ST_W-1:0] st,
                                            skt_pkg::rec_type r, logic fin);
      rsp_rec_type e;
      e.status = st;
      e.key = r.key;
      e.total = r.total;
      e.borrowed = r.borrowed;
      e.remaining = {1'b0, r.total} - {1'b0, r.borrowed};
      e.last = fin;
      return e;
   endfunction

   function automatic int find_key(logic [skt_pkg::KEY_W-1:0] k);
      foreach (shadow_table[i])
         if (shadow_table[i].key == k) return i;
      return -1;
   endfunction

   task automatic predict_table(logic [skt_pkg::CMD_W-1:0] cmd, skt_pkg::rec_type r);
      int pos;
      skt_pkg::rec_type blank;
      blank = '0;
      pos = find_key(r.key);
      unique case (cmd)
         skt_pkg::CMD_INSERT: begin
            if (pos >= 0) expected_rsp.push_back(make_rsp(skt_pkg::ST_DUP, blank, 1'b1));
            else if (shadow_table.size() >= CAPACITY)
               expected_rsp.push_back(make_rsp(skt_pkg::ST_FULL, blank, 1'b1));
            else begin
               pos = 0;
               while (pos < shadow_table.size() && shadow_table[pos].key < r.key) pos++;
               shadow_table.insert(pos, r);
               expected_rsp.push_back(make_rsp(skt_pkg::ST_OK, r, 1'b1));
            end
         end
         skt_pkg::CMD_LOOKUP, skt_pkg::CMD_UPDATE: begin
            if (pos < 0)
               expected_rsp.push_back(make_rsp(skt_pkg::ST_NOTFOUND, blank, 1'b1));
            else begin
               if (cmd == skt_pkg::CMD_UPDATE) shadow_table[pos] = r;
               expected_rsp.push_back(make_rsp(skt_pkg::ST_OK, shadow_table[pos], 1'b1));
            end
         end
         skt_pkg::CMD_DELETE: begin
            if (shadow_table.size() == 0)
               expected_rsp.push_back(make_rsp(skt_pkg::ST_EMPTY, blank, 1'b1));
            else if (pos < 0)
               expected_rsp.push_back(make_rsp(skt_pkg::ST_NOTFOUND, blank, 1'b1));
            else begin
               expected_rsp.push_back(make_rsp(skt_pkg::ST_OK, shadow_table[pos], 1'b1));
               shadow_table.delete(pos);
            end
         end
         skt_pkg::CMD_LIST: begin
            if (shadow_table.size() == 0)
               expected_rsp.push_back(make_rsp(skt_pkg::ST_EMPTY, blank, 1'b1));
            else
               foreach (shadow_table[i])
                  expected_rsp.push_back(make_rsp(skt_pkg::ST_OK, shadow_table[i],
                     i == shadow_table.size() - 1));
         end
         default: ;  // undefined commands are dropped
      endcase
   endtask

   task automatic check_field(string name, longint exp, longint act);
      if (exp != act) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp, act);
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   assign pending_count = expected_rsp.size();
   assign table_count = shadow_table.size();

   always @(posedge clock) begin
      rsp_rec_type e;
      skt_pkg::rec_type r;
      if (reset) begin
         shadow_table.delete();
         expected_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no transaction outstanding");
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("status", e.status, rsp_status);
               check_field("out_key", e.key, rsp_out_key);
               check_field("out_total", e.total, rsp_out_total);
               check_field("out_borrowed", e.borrowed, rsp_out_borrowed);
               check_field("out_remaining", e.remaining, $unsigned(rsp_out_remaining));
               check_field("last", e.last, rsp_last);
            end
         end
         if (start && !busy) begin
            r.key = req_key;
            r.total = req_total_count;
            r.borrowed = req_borrowed_count;
            predict_table(req_cmd, r);
         end
      end
   end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench top: drives commands into sorted_key_table and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [skt_pkg::CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
   localparam logic [skt_pkg::CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [skt_pkg::CMD_W-1:0] req_cmd = skt_pkg::CMD_LIST;
   logic [skt_pkg::KEY_W-1:0] req_key = '0;
   logic [skt_pkg::CNT_W-1:0] req_total_count = '0;
   logic [skt_pkg::CNT_W-1:0] req_borrowed_count = '0;
   logic rsp_valid;
   logic [skt_pkg::ST_W-1:0] rsp_status;
   logic [skt_pkg::KEY_W-1:0] rsp_out_key;
   logic [skt_pkg::CNT_W-1:0] rsp_out_total;
   logic [skt_pkg::CNT_W-1:0] rsp_out_borrowed;
   logic signed [skt_pkg::CNT_W:0] rsp_out_remaining;
   logic rsp_last;
   int fail_count, pending_count, table_count;
   int idle_cycles = 0;
   logic [skt_pkg::KEY_W-1:0] used_keys[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sorted_key_table #(.CAPACITY(skt_pkg::CAPACITY_DEF)) i_dut (.*);

   skt_checker #(.CAPACITY(skt_pkg::CAPACITY_DEF)) i_checker (.*);

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_cmd(logic [skt_pkg::CMD_W-1:0] cmd, logic [skt_pkg::KEY_W-1:0] k,
                           logic [skt_pkg::CNT_W-1:0] tot, logic [skt_pkg::CNT_W-1:0] bor);
      req_cmd <= cmd;
      req_key <= k;
      req_total_count <= tot;
      req_borrowed_count <= bor;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (cmd == skt_pkg::CMD_INSERT) used_keys.push_back(k);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
      if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      return $urandom_range(0, 3) == 0 ? skt_pkg::KEY_W'($urandom)
                                       : skt_pkg::KEY_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [skt_pkg::CMD_W-1:0] pick_cmd();
      int w;
      w = $urandom_range(0, 99);
      if (w < 5) return skt_pkg::CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      if (w < 12) return skt_pkg::CMD_LIST;
      if (w < 24) return skt_pkg::CMD_DELETE;
      if (w < 36) return skt_pkg::CMD_UPDATE;
      if (w < 55) return skt_pkg::CMD_LOOKUP;
      return (table_count > 28 && w < 80) ? skt_pkg::CMD_DELETE : skt_pkg::CMD_INSERT;
   endfunction

   initial begin
      int burst;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: empty-table cases, extremes, duplicates, negative remaining
      send_cmd(skt_pkg::CMD_LIST, 16'h0, 16'h0, 16'h0);
      send_cmd(skt_pkg::CMD_DELETE, 16'h5, 16'h0, 16'h0);
      send_cmd(skt_pkg::CMD_LOOKUP, 16'h5, 16'h0, 16'h0);
      send_cmd(skt_pkg::CMD_UPDATE, 16'h5, 16'h1, 16'h1);
      send_cmd(skt_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_cmd(skt_pkg::CMD_INSERT, 16'h0000, 16'h0000, 16'hFFFF);
      send_cmd(skt_pkg::CMD_INSERT, 16'h8000, 16'h5555, 16'hAAAA);
      send_cmd(skt_pkg::CMD_INSERT, 16'h8000, 16'h1, 16'h1);
      send_cmd(skt_pkg::CMD_LOOKUP, 16'hFFFF, 16'h0, 16'h0);
      send_cmd(skt_pkg::CMD_UPDATE, 16'h0000, 16'hAAAA, 16'h5555);
      send_cmd(skt_pkg::CMD_LOOKUP, 16'h1234, 16'h0, 16'h0);
      send_cmd(skt_pkg::CMD_LIST, 16'h0, 16'h0, 16'h0);
      send_cmd(CMD_UNDEF_LO, 16'h1, 16'h1, 16'h1);
      send_cmd(CMD_UNDEF_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(skt_pkg::CMD_DELETE, 16'h8000, 16'h0, 16'h0);
      send_cmd(skt_pkg::CMD_DELETE, 16'h8000, 16'h0, 16'h0);
      drain();
      // fill to capacity, then hit full and duplicate-on-full
      for (int i = 0; i < 31; i++)
         send_cmd(skt_pkg::CMD_INSERT, skt_pkg::KEY_W'(16'h0100 + i * 7),
                  skt_pkg::CNT_W'($urandom), skt_pkg::CNT_W'($urandom));
      send_cmd(skt_pkg::CMD_INSERT, 16'h0042, 16'h1, 16'h2);
      send_cmd(skt_pkg::CMD_INSERT, 16'h0100, 16'h1, 16'h2);
      send_cmd(skt_pkg::CMD_LIST, 16'h0, 16'h0, 16'h0);
      drain();
      // random bursts
      for (int n = 0; n < 300; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++, n++)
            send_cmd(pick_cmd(), pick_key(), skt_pkg::CNT_W'($urandom),
                     skt_pkg::CNT_W'($urandom));
         start <= 1'b0;
         if ($urandom_range(0, 9) == 0) drain();
         else repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      drain();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
